>>> rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles package
// Shared widths, fixed-point constants, the arctangent table and the
// operand bundle that travels through the square root pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QUAT_W          = 16;
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 4;

    // Exact products of two components and the doubled sums of two products.
    localparam int PROD_W = 2 * QUAT_W;
    localparam int TERM_W = PROD_W + 4;
    localparam logic signed [TERM_W-1:0] TERM_ONE =
        TERM_W'(64'sd1 <<< (2 * QUAT_FRAC_BITS));

    // Pitch argument rescaled to 30 fraction bits.
    localparam int T30_W   = 32;
    localparam int T30_SHL = 30 - 2 * QUAT_FRAC_BITS;
    localparam int ROOT_W  = 31;
    localparam int RAD_W   = 61;
    localparam int ACC_W   = 62;
    localparam int SQRT_STEPS = 31;

    // Vectoring rotator.
    localparam int CORDIC_STEPS = 20;
    localparam int TAB_FRAC     = 20;
    localparam int CW           = 43;
    localparam int ZW           = 30;
    localparam int MAG_W        = TERM_W + 1;
    localparam int SHIFT_W      = 6;
    localparam int NORM_MSB     = 39;
    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 <<< TAB_FRAC);
    localparam int ROUND_SHIFT  = TAB_FRAC - ANGLE_FRAC_BITS;

    localparam int ANG_W   = 13;
    localparam int PITCH_W = 12;
    localparam logic signed [ANG_W-1:0] LIMIT_HALF    = ANG_W'(180 <<< ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] LIMIT_QUARTER = ANG_W'(90 <<< ANGLE_FRAC_BITS);

    typedef struct packed {
        logic signed [TERM_W-1:0] t0;
        logic signed [TERM_W-1:0] t1;
        logic signed [TERM_W-1:0] t3;
        logic signed [TERM_W-1:0] t4;
        logic signed [T30_W-1:0]  t30;
        logic                     clipped;
    } side_t;

    // atan(2^-i) in degrees with TAB_FRAC fraction bits.
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = ZW'(47185920);
            1:  v = ZW'(27855475);
            2:  v = ZW'(14718068);
            3:  v = ZW'(7471121);
            4:  v = ZW'(3750058);
            5:  v = ZW'(1876857);
            6:  v = ZW'(938658);
            7:  v = ZW'(469357);
            8:  v = ZW'(234682);
            9:  v = ZW'(117342);
            10: v = ZW'(58671);
            11: v = ZW'(29335);
            12: v = ZW'(14668);
            13: v = ZW'(7334);
            14: v = ZW'(3667);
            15: v = ZW'(1833);
            16: v = ZW'(917);
            17: v = ZW'(458);
            18: v = ZW'(229);
            19: v = ZW'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/qte_terms.sv
// ----------------------------------------------------------------------------
// Quaternion product terms
// Forms the roll, pitch and yaw operands exactly, saturates the pitch
// argument and builds the radicand 1 - t^2 over four register stages.
// ----------------------------------------------------------------------------
module qte_terms (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [qte_pkg::QUAT_W-1:0]       quat_w,
    input  logic signed [qte_pkg::QUAT_W-1:0]       quat_x,
    input  logic signed [qte_pkg::QUAT_W-1:0]       quat_y,
    input  logic signed [qte_pkg::QUAT_W-1:0]       quat_z,
    output logic                                    out_valid,
    output qte_pkg::side_t                          out_side,
    output logic [qte_pkg::RAD_W-1:0]               out_rad
);

    localparam int PW = qte_pkg::PROD_W;
    localparam int TW = qte_pkg::TERM_W;

    logic [3:0] valid_reg;

    logic signed [PW-1:0] wx_reg, yz_reg, wy_reg, zx_reg, wz_reg, xy_reg;
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg;

    logic signed [TW-1:0] wx_e, yz_e, wy_e, zx_e, wz_e, xy_e, xx_e, yy_e, zz_e;
    logic signed [TW-1:0] t2_raw;
    logic signed [TW-1:0] t2_sat;
    qte_pkg::side_t       side_next;
    logic [qte_pkg::ROOT_W-1:0] mag_next;

    qte_pkg::side_t             side2_reg, side3_reg, side4_reg;
    logic [qte_pkg::ROOT_W-1:0] mag_reg;
    logic [qte_pkg::ACC_W-1:0]  sq_reg;
    logic [qte_pkg::RAD_W-1:0]  rad_reg;

    always_comb begin
        wx_e = TW'(wx_reg);
        yz_e = TW'(yz_reg);
        wy_e = TW'(wy_reg);
        zx_e = TW'(zx_reg);
        wz_e = TW'(wz_reg);
        xy_e = TW'(xy_reg);
        xx_e = TW'(xx_reg);
        yy_e = TW'(yy_reg);
        zz_e = TW'(zz_reg);

        side_next.t0 = (wx_e + yz_e) <<< 1;
        side_next.t1 = qte_pkg::TERM_ONE - ((xx_e + yy_e) <<< 1);
        side_next.t3 = (wz_e + xy_e) <<< 1;
        side_next.t4 = qte_pkg::TERM_ONE - ((yy_e + zz_e) <<< 1);
        t2_raw       = (wy_e - zx_e) <<< 1;

        priority if (t2_raw > qte_pkg::TERM_ONE) begin
            t2_sat            = qte_pkg::TERM_ONE;
            side_next.clipped = 1'b1;
        end else if (t2_raw < -qte_pkg::TERM_ONE) begin
            t2_sat            = -qte_pkg::TERM_ONE;
            side_next.clipped = 1'b1;
        end else begin
            t2_sat            = t2_raw;
            side_next.clipped = 1'b0;
        end

        side_next.t30 = qte_pkg::T30_W'(t2_sat <<< qte_pkg::T30_SHL);
        mag_next = side_next.t30[qte_pkg::T30_W-1]
                 ? qte_pkg::ROOT_W'(-side_next.t30)
                 : qte_pkg::ROOT_W'(side_next.t30);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg    <= quat_w * quat_x;
            yz_reg    <= quat_y * quat_z;
            wy_reg    <= quat_w * quat_y;
            zx_reg    <= quat_z * quat_x;
            wz_reg    <= quat_w * quat_z;
            xy_reg    <= quat_x * quat_y;
            xx_reg    <= quat_x * quat_x;
            yy_reg    <= quat_y * quat_y;
            zz_reg    <= quat_z * quat_z;
            side2_reg <= side_next;
            mag_reg   <= mag_next;
            side3_reg <= side2_reg;
            sq_reg    <= qte_pkg::ACC_W'(mag_reg) * qte_pkg::ACC_W'(mag_reg);
            side4_reg <= side3_reg;
            rad_reg   <= qte_pkg::RAD_W'((qte_pkg::ACC_W'(1) << 60) - sq_reg);
        end
    end

    assign out_valid = valid_reg[3];
    assign out_side  = side4_reg;
    assign out_rad   = rad_reg;

endmodule

>>> rtl/qte_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage, with
// the angle operands riding alongside.
// ----------------------------------------------------------------------------
module qte_isqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  qte_pkg::side_t                  in_side,
    input  logic [qte_pkg::RAD_W-1:0]       in_rad,
    output logic                            out_valid,
    output qte_pkg::side_t                  out_side,
    output logic [qte_pkg::ROOT_W-1:0]      out_root
);

    localparam int N  = qte_pkg::SQRT_STEPS;
    localparam int AW = qte_pkg::ACC_W;

    logic [N-1:0]                  valid_reg;
    qte_pkg::side_t                side_reg [N];
    logic [qte_pkg::RAD_W-1:0]     rem_reg  [N];
    logic [AW-1:0]                 acc_reg  [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [AW-1:0] BIT = AW'(1) << (2 * (N - 1 - k));
        logic [qte_pkg::RAD_W-1:0] rem_in;
        logic [AW-1:0]             acc_in;
        logic [AW-1:0]             trial;
        logic [qte_pkg::RAD_W-1:0] rem_next;
        logic [AW-1:0]             acc_next;

        if (k == 0) begin : g_first
            assign rem_in = in_rad;
            assign acc_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        always_comb begin
            trial = acc_in + BIT;
            if (AW'(rem_in) >= trial) begin
                rem_next = qte_pkg::RAD_W'(AW'(rem_in) - trial);
                acc_next = (acc_in >> 1) + BIT;
            end else begin
                rem_next = rem_in;
                acc_next = acc_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                acc_reg[k] <= acc_next;
                if (k == 0) begin
                    side_reg[k] <= in_side;
                end else begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_root  = acc_reg[N-1][qte_pkg::ROOT_W-1:0];

endmodule

>>> rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined vectoring rotator for atan2
// Normalizes both operands by a common power of two, folds the left half
// plane, runs one rotation per stage and rounds to the output step.
// ----------------------------------------------------------------------------
module qte_cordic (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [qte_pkg::TERM_W-1:0]   y_in,
    input  logic signed [qte_pkg::TERM_W-1:0]   x_in,
    output logic signed [qte_pkg::ANG_W-1:0]    angle
);

    localparam int S  = qte_pkg::CORDIC_STEPS;
    localparam int CW = qte_pkg::CW;
    localparam int ZW = qte_pkg::ZW;
    localparam int MW = qte_pkg::MAG_W;
    localparam int RS = qte_pkg::ROUND_SHIFT;

    // Leading one search.
    logic [MW-1:0]                    mag_or;
    logic [qte_pkg::SHIFT_W-1:0]      msb_pos;
    logic signed [qte_pkg::TERM_W-1:0] xa_reg, ya_reg;
    logic [qte_pkg::SHIFT_W-1:0]      shift_reg;
    logic                             zero_a_reg;

    always_comb begin
        mag_or  = (x_in[qte_pkg::TERM_W-1] ? MW'(-MW'(x_in)) : MW'(x_in))
                | (y_in[qte_pkg::TERM_W-1] ? MW'(-MW'(y_in)) : MW'(y_in));
        msb_pos = '0;
        for (int i = 0; i < MW; i++) begin
            if (mag_or[i]) begin
                msb_pos = qte_pkg::SHIFT_W'(i);
            end
        end
    end

    // Normalized operands, then the half-plane fold.
    logic signed [CW-1:0] xn_reg, yn_reg;
    logic                 zero_n_reg;
    logic signed [CW-1:0] xf_next, yf_next;
    logic signed [ZW-1:0] zf_next;

    always_comb begin
        if (xn_reg < 0) begin
            if (yn_reg >= 0) begin
                xf_next = yn_reg;
                yf_next = -xn_reg;
                zf_next = qte_pkg::Z_QUARTER;
            end else begin
                xf_next = -yn_reg;
                yf_next = xn_reg;
                zf_next = -qte_pkg::Z_QUARTER;
            end
        end else begin
            xf_next = xn_reg;
            yf_next = yn_reg;
            zf_next = '0;
        end
    end

    logic signed [CW-1:0] x_reg    [S+1];
    logic signed [CW-1:0] y_reg    [S+1];
    logic signed [ZW-1:0] z_reg    [S+1];
    logic                 zero_reg [S+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg      <= x_in;
            ya_reg      <= y_in;
            shift_reg   <= qte_pkg::SHIFT_W'(qte_pkg::NORM_MSB) - msb_pos;
            zero_a_reg  <= (mag_or == '0);
            xn_reg      <= CW'(xa_reg) <<< shift_reg;
            yn_reg      <= CW'(ya_reg) <<< shift_reg;
            zero_n_reg  <= zero_a_reg;
            x_reg[0]    <= xf_next;
            y_reg[0]    <= yf_next;
            z_reg[0]    <= zf_next;
            zero_reg[0] <= zero_n_reg;
        end
    end

    for (genvar i = 0; i < S; i++) begin : g_rot
        localparam logic signed [ZW-1:0] STEP_ANGLE = qte_pkg::atan_entry(i);
        logic signed [CW-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + STEP_ANGLE;
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - STEP_ANGLE;
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // Round half away from zero on the magnitude.
    logic [ZW-1:0]                  z_mag;
    logic [ZW-1:0]                  z_rnd;
    logic signed [qte_pkg::ANG_W-1:0] angle_next;
    logic signed [qte_pkg::ANG_W-1:0] angle_reg;

    always_comb begin
        z_mag = z_reg[S][ZW-1] ? ZW'(-z_reg[S]) : ZW'(z_reg[S]);
        z_rnd = (z_mag + (ZW'(1) << (RS - 1))) >> RS;
        if (zero_reg[S]) begin
            angle_next = '0;
        end else if (z_reg[S][ZW-1]) begin
            angle_next = -qte_pkg::ANG_W'(z_rnd);
        end else begin
            angle_next = qte_pkg::ANG_W'(z_rnd);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

>>> rtl/quaternion_to_euler_angles_unit.sv
// Pipeline: 4 term stages, 31 square root stages, 24 rotator stages and
// 1 output register between input transaction and result.
// Throughput: one transaction per cycle; the whole pipeline holds while
// a result waits on m_tready. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
// Quaternion to Euler angles unit
// Converts a unit quaternion in Q2.14 into roll, pitch and yaw in degrees
// with four fraction bits, using pipelined square root and atan2 units.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // roll_deg [12:0], pitch_deg [24:13], yaw_deg [37:25], zero fill [39:38]
    output logic [39:0] m_tdata,
    // pitch_clipped [0]
    output logic [0:0]  m_tuser
);

    localparam int CLAT = qte_pkg::CORDIC_STEPS + 4;
    localparam int AW   = qte_pkg::ANG_W;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic                            terms_valid;
    qte_pkg::side_t                  terms_side;
    logic [qte_pkg::RAD_W-1:0]       terms_rad;

    qte_terms u_terms (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .quat_w    (s_tdata[15:0]),
        .quat_x    (s_tdata[31:16]),
        .quat_y    (s_tdata[47:32]),
        .quat_z    (s_tdata[63:48]),
        .out_valid (terms_valid),
        .out_side  (terms_side),
        .out_rad   (terms_rad)
    );

    logic                            root_valid;
    qte_pkg::side_t                  root_side;
    logic [qte_pkg::ROOT_W-1:0]      root;

    qte_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (terms_valid),
        .in_side   (terms_side),
        .in_rad    (terms_rad),
        .out_valid (root_valid),
        .out_side  (root_side),
        .out_root  (root)
    );

    logic signed [AW-1:0] roll_raw, pitch_raw, yaw_raw;

    qte_cordic u_roll (
        .aclk  (aclk),
        .en    (adv),
        .y_in  (root_side.t0),
        .x_in  (root_side.t1),
        .angle (roll_raw)
    );

    qte_cordic u_pitch (
        .aclk  (aclk),
        .en    (adv),
        .y_in  (qte_pkg::TERM_W'(root_side.t30)),
        .x_in  ($signed(qte_pkg::TERM_W'(root))),
        .angle (pitch_raw)
    );

    qte_cordic u_yaw (
        .aclk  (aclk),
        .en    (adv),
        .y_in  (root_side.t3),
        .x_in  (root_side.t4),
        .angle (yaw_raw)
    );

    // Valid and clip flag follow the rotators stage for stage.
    logic [CLAT-1:0] rot_valid_reg;
    logic [CLAT-1:0] rot_clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_valid_reg <= '0;
        end else if (adv) begin
            rot_valid_reg <= {rot_valid_reg[CLAT-2:0], root_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rot_clip_reg <= {rot_clip_reg[CLAT-2:0], root_side.clipped};
        end
    end

    function automatic logic signed [AW-1:0] clamp_angle(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] lim
    );
        logic signed [AW-1:0] r;
        priority if (a > lim) begin
            r = lim;
        end else if (a < -lim) begin
            r = -lim;
        end else begin
            r = a;
        end
        return r;
    endfunction

    logic signed [AW-1:0] roll_next, pitch_next, yaw_next;
    logic [AW-1:0]                   roll_reg, yaw_reg;
    logic [qte_pkg::PITCH_W-1:0]     pitch_reg;
    logic                            clip_reg;
    logic                            out_valid_reg;

    assign roll_next  = clamp_angle(roll_raw, qte_pkg::LIMIT_HALF);
    assign pitch_next = clamp_angle(pitch_raw, qte_pkg::LIMIT_QUARTER);
    assign yaw_next   = clamp_angle(yaw_raw, qte_pkg::LIMIT_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= rot_valid_reg[CLAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next[qte_pkg::PITCH_W-1:0];
            yaw_reg   <= yaw_next;
            clip_reg  <= rot_clip_reg[CLAT-1];
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {2'b00, yaw_reg, pitch_reg, roll_reg};
    assign m_tuser[0] = clip_reg;

endmodule

>>> sim/quaternion_to_euler_angles_unit_test.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles unit testbench
// Drives quaternions through the stream input with bursts and gaps, stalls
// the result side on its own pattern, and compares every result against a
// bit-accurate predictor of the fixed-point CORDIC conversion.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit_test;

    localparam int N_RANDOM  = 2000;
    localparam int WATCHDOG  = 5000;
    localparam int DRAIN     = 80;
    localparam int N_DIRECT  = 18;
    localparam logic [15:0] Q_ONE = 16'h4000;
    localparam logic [15:0] Q_MONE = 16'hC000;

    typedef struct packed {
        logic [12:0] roll;
        logic [11:0] pitch;
        logic [12:0] yaw;
        logic        clipped;
    } angles_t;

    typedef struct {
        logic [15:0] w, x, y, z;
        bit          known;
        angles_t     ang;
    } quat_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    quaternion_to_euler_angles_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    angles_t     angle_queue[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          clipped_seen = 0;
    int          idle_cycles = 0;
    bit          timed_out = 0;
    quat_row_t   quat_table[N_DIRECT];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Floor shift, valid for negative values as well.
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint rotate_to_angle(input longint yv, input longint xv);
        longint ang, t, xs, ys;
        longint tab[20] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                            938658, 469357, 234682, 117342, 58671, 29335, 14668,
                            7334, 3667, 1833, 917, 458, 229, 115};
        ang = 0;
        if (xv == 0 && yv == 0) return 0;
        while (mag(xv) >= (64'sd1 <<< 40) || mag(yv) >= (64'sd1 <<< 40)) begin
            xv = floor_shr(xv, 1);
            yv = floor_shr(yv, 1);
        end
        while (mag(xv) < (64'sd1 <<< 39) && mag(yv) < (64'sd1 <<< 39)) begin
            xv = xv * 2;
            yv = yv * 2;
        end
        // Fold the left half plane into the right one by a quarter turn.
        if (xv < 0) begin
            t = xv;
            if (yv >= 0) begin
                xv = yv; yv = -t; ang = 64'sd90 <<< 20;
            end else begin
                xv = -yv; yv = t; ang = -(64'sd90 <<< 20);
            end
        end
        for (int i = 0; i < 20; i++) begin
            xs = floor_shr(xv, i);
            ys = floor_shr(yv, i);
            if (yv > 0) begin
                xv += ys; yv -= xs; ang += tab[i];
            end else begin
                xv -= ys; yv += xs; ang -= tab[i];
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_degrees(input longint a, input longint lim_deg);
        longint m, r, lim;
        lim = lim_deg <<< 4;
        m = (mag(a) + (64'sd1 <<< 15)) >>> 16;
        r = (a < 0) ? -m : m;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic angles_t euler_from_quat(input logic [15:0] qw, input logic [15:0] qx,
                                                input logic [15:0] qy, input logic [15:0] qz);
        longint w, x, y, z, one, t0, t1, t2, t3, t4, t30;
        longint unsigned u, c;
        angles_t res;
        w = longint'($signed(qw)); x = longint'($signed(qx));
        y = longint'($signed(qy)); z = longint'($signed(qz));
        one = 64'sd1 <<< 28;
        t0 = 2 * (w * x + y * z);
        t1 = one - 2 * (x * x + y * y);
        t2 = 2 * (w * y - z * x);
        t3 = 2 * (w * z + x * y);
        t4 = one - 2 * (y * y + z * z);
        res.clipped = 1'b0;
        if (t2 > one) begin
            t2 = one; res.clipped = 1'b1;
        end else if (t2 < -one) begin
            t2 = -one; res.clipped = 1'b1;
        end
        t30 = t2 * 4;
        u = longint'(mag(t30));
        c = int_sqrt((64'd1 << 60) - u * u);
        res.roll  = 13'(round_degrees(rotate_to_angle(t0, t1), 180));
        res.pitch = 12'(round_degrees(rotate_to_angle(t30, longint'(c)), 90));
        res.yaw   = 13'(round_degrees(rotate_to_angle(t3, t4), 180));
        return res;
    endfunction

    // Result side: stall pattern and checking.
    always @(posedge aclk) begin
        angles_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            // Mostly ready, with random stalls.
            m_tready <= (($urandom & 255) < 200) ? 1'b1 : ($urandom_range(0, 3) == 0);
            if (m_tvalid && m_tready) begin
                got.roll = m_tdata[12:0];
                got.pitch = m_tdata[24:13];
                got.yaw = m_tdata[37:25];
                got.clipped = m_tuser[0];
                results_seen++;
                if (got.clipped) clipped_seen++;
                if (angle_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result roll=%0d pitch=%0d yaw=%0d",
                                 $signed(got.roll), $signed(got.pitch), $signed(got.yaw));
                end else begin
                    want = angle_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: expected r/p/y/c %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                     $signed(want.roll), $signed(want.pitch),
                                     $signed(want.yaw), want.clipped,
                                     $signed(got.roll), $signed(got.pitch),
                                     $signed(got.yaw), got.clipped);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("ERROR: watchdog expired");
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input bit known, input angles_t typed);
        angles_t pred;
        pred = euler_from_quat(w, x, y, z);
        if (known && pred !== typed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: predictor disagrees with table for %h %h %h %h",
                         w, x, y, z);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        angle_queue.push_back(known ? typed : pred);
    endtask

    task automatic sender_gap();
        int n;
        n = $urandom_range(0, 2) == 0 ? $urandom_range(1, 6) : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Random quaternion: mostly near-unit from a random vector, some raw random bits.
    task automatic random_quat(output logic [15:0] w, output logic [15:0] x,
                               output logic [15:0] y, output logic [15:0] z);
        int kind;
        real a, b, c, d, n;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            a = $urandom_range(0, 65535) - 32768.0;
            b = $urandom_range(0, 65535) - 32768.0;
            c = $urandom_range(0, 65535) - 32768.0;
            d = $urandom_range(0, 65535) - 32768.0;
            if (kind == 0) c = c / 4096.0 + 23170.0 * ($urandom_range(0, 1) ? 1 : -1);
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) n = 1.0;
            w = 16'($rtoi(a * 16384.0 / n)); x = 16'($rtoi(b * 16384.0 / n));
            y = 16'($rtoi(c * 16384.0 / n)); z = 16'($rtoi(d * 16384.0 / n));
            if (kind == 0) begin
                w = y; z = 16'(-$signed(x) + $signed(16'($urandom_range(0, 7))) - 3);
            end
        end else begin
            {w, x, y, z} = {$urandom, $urandom};
        end
    endtask

    initial begin
        logic [15:0] w, x, y, z;
        int burst;
        quat_table = '{
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
            '{Q_ONE,    16'h0000, 16'h0000, 16'h0000, 1'b1, '0},
            '{Q_MONE,   16'h0000, 16'h0000, 16'h0000, 1'b1, '0},
            '{16'h0000, Q_ONE,    16'h0000, 16'h0000, 1'b1, '{13'(180*16), 12'd0, 13'd0, 1'b0}},
            '{16'h0000, 16'h0000, 16'h0000, Q_ONE,    1'b1, '{13'd0, 12'd0, 13'(180*16), 1'b0}},
            '{16'h2D41, 16'h0000, 16'h2D41, 16'h0000, 1'b0, '0},
            '{16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 1'b0, '0},
            '{Q_ONE,    16'h0000, Q_ONE,    16'h0000, 1'b1,
              '{13'(180*16), 12'(90*16), 13'(180*16), 1'b1}},
            '{Q_ONE,    16'h0000, Q_MONE,   16'h0000, 1'b1,
              '{13'(180*16), 12'(-90*16), 13'(180*16), 1'b1}},
            '{16'h2D41, 16'h2D41, 16'h0000, 16'h0000, 1'b0, '0},
            '{16'h2D41, 16'h0000, 16'h0000, 16'hD2BF, 1'b0, '0},
            '{16'h2000, 16'h2000, 16'h2000, 16'h2000, 1'b0, '0},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
            '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
            '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, '0},
            '{16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 1'b0, '0},
            '{16'h0000, 16'h0000, Q_ONE,    16'h0000, 1'b0, '0},
            '{16'h1234, 16'hEDCB, 16'h3A5F, 16'hC00F, 1'b0, '0}
        };
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (quat_table[i]) begin
            send_quat(quat_table[i].w, quat_table[i].x, quat_table[i].y, quat_table[i].z,
                      quat_table[i].known, quat_table[i].ang);
            sender_gap();
        end

        for (int k = 0; k < N_RANDOM; k += burst) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst; j++) begin
                random_quat(w, x, y, z);
                send_quat(w, x, y, z, 1'b0, '0);
            end
            // Once, halfway, hold off until the pipeline has fully drained.
            if (k < N_RANDOM / 2 && k + burst >= N_RANDOM / 2) begin
                s_tvalid <= 1'b0;
                while (angle_queue.size() != 0) @(posedge aclk);
            end else begin
                sender_gap();
            end
        end
        s_tvalid <= 1'b0;

        while (angle_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("Checked %0d orientations (%0d directed), %0d with a clipped pitch.",
                 results_seen, N_DIRECT, clipped_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
